// ----- hdl/luiu_pkg.sv -----
`timescale 1ns / 1ps

package luiu_pkg;

  localparam int ElemWidth = 32;

  // Codes carried in the input tuser field.
  typedef enum logic [1:0] {
    MODE_PUSH_A  = 2'd0,
    MODE_PUSH_B  = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  // Values of the operation register.
  localparam logic OP_UNION = 1'b0;
  localparam logic OP_INTER = 1'b1;

  // Jump conditions of the microcode.
  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_INTER    = 3'd2,
    COND_I_END    = 3'd3,
    COND_J_OTHER  = 3'd4,
    COND_J_PREFIX = 3'd5
  } cond_e;

  // Choice of the walked list.
  typedef enum logic [1:0] {
    WS_KEEP   = 2'd0,
    WS_A      = 2'd1,
    WS_B      = 2'd2,
    WS_LONGER = 2'd3
  } wsel_e;

  typedef logic [3:0] step_t;

  localparam step_t ST_START    = 4'd0;
  localparam step_t ST_A_CHECK  = 4'd1;
  localparam step_t ST_A_LATCH  = 4'd2;
  localparam step_t ST_A_EMIT   = 4'd3;
  localparam step_t ST_B_SETUP  = 4'd4;
  localparam step_t ST_X_SETUP  = 4'd5;
  localparam step_t ST_OUTER    = 4'd6;
  localparam step_t ST_LATCH    = 4'd7;
  localparam step_t ST_O_CHECK  = 4'd8;
  localparam step_t ST_O_CMP    = 4'd9;
  localparam step_t ST_P_SETUP  = 4'd10;
  localparam step_t ST_P_CHECK  = 4'd11;
  localparam step_t ST_P_CMP    = 4'd12;
  localparam step_t ST_DECIDE   = 4'd13;
  localparam step_t ST_FINISH   = 4'd14;

  typedef struct packed {
    cond_e  cond;
    step_t  target;
    wsel_e  wsel;
    logic   clr_i;
    logic   inc_i;
    logic   clr_j;
    logic   inc_j;
    logic   clr_hit;
    logic   latch;
    logic   cmp_other;
    logic   cmp_prefix;
    logic   emit_all;
    logic   emit_match;
    logic   finish;
  } ctrl_t;

  typedef struct packed {
    logic i_end;
    logic j_other_end;
    logic j_prefix_end;
    logic out_free;
  } stat_t;

  // Microcode ROM. The walked list is read at index i, the searched list at j.
  function automatic ctrl_t luiu_ucode(step_t step);
    ctrl_t w;
    w = '0;
    case (step)
      ST_START: begin
        w.wsel = WS_A; w.clr_i = 1'b1;
        w.cond = COND_INTER; w.target = ST_X_SETUP;
      end
      ST_A_CHECK: begin
        w.cond = COND_I_END; w.target = ST_B_SETUP;
      end
      ST_A_LATCH: begin
        w.latch = 1'b1;
      end
      ST_A_EMIT: begin
        w.emit_all = 1'b1; w.inc_i = 1'b1;
        w.cond = COND_ALWAYS; w.target = ST_A_CHECK;
      end
      ST_B_SETUP: begin
        w.wsel = WS_B; w.clr_i = 1'b1;
        w.cond = COND_ALWAYS; w.target = ST_OUTER;
      end
      ST_X_SETUP: begin
        w.wsel = WS_LONGER; w.clr_i = 1'b1;
      end
      ST_OUTER: begin
        w.clr_j = 1'b1; w.clr_hit = 1'b1;
        w.cond = COND_I_END; w.target = ST_FINISH;
      end
      ST_LATCH: begin
        w.latch = 1'b1;
      end
      ST_O_CHECK: begin
        w.cond = COND_J_OTHER; w.target = ST_P_SETUP;
      end
      ST_O_CMP: begin
        w.cmp_other = 1'b1; w.inc_j = 1'b1;
        w.cond = COND_ALWAYS; w.target = ST_O_CHECK;
      end
      ST_P_SETUP: begin
        w.clr_j = 1'b1;
        w.cond = COND_INTER; w.target = ST_DECIDE;
      end
      ST_P_CHECK: begin
        w.cond = COND_J_PREFIX; w.target = ST_DECIDE;
      end
      ST_P_CMP: begin
        w.cmp_prefix = 1'b1; w.inc_j = 1'b1;
        w.cond = COND_ALWAYS; w.target = ST_P_CHECK;
      end
      ST_DECIDE: begin
        w.emit_match = 1'b1; w.inc_i = 1'b1;
        w.cond = COND_ALWAYS; w.target = ST_OUTER;
      end
      ST_FINISH: begin
        w.finish = 1'b1;
      end
      default: begin
        w.finish = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/luiu_seq.sv -----
`timescale 1ns / 1ps

module luiu_seq
  import luiu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  op_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);

  step_t upc_q;
  logic  busy_q;
  ctrl_t rom_w;
  logic  stall;
  logic  run;
  logic  taken;

  assign rom_w = luiu_ucode(upc_q);

  // A step that writes the output register waits until that register is free.
  assign stall = (rom_w.emit_all || rom_w.emit_match || rom_w.finish) && !stat_i.out_free;
  assign run   = busy_q && !stall;

  always_comb begin
    case (rom_w.cond)
      COND_NEXT:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_INTER:    taken = (op_i == OP_INTER);
      COND_I_END:    taken = stat_i.i_end;
      COND_J_OTHER:  taken = stat_i.j_other_end;
      COND_J_PREFIX: taken = stat_i.j_prefix_end;
      default:       taken = 1'b0;
    endcase
  end

  assign ctrl_o = run ? rom_w : '0;
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= ST_START;
    end else if (start_i) begin
      busy_q <= 1'b1;
      upc_q  <= ST_START;
    end else if (run) begin
      if (rom_w.finish) begin
        busy_q <= 1'b0;
      end
      upc_q <= taken ? rom_w.target : upc_q + step_t'(1);
    end
  end

endmodule

// ----- hdl/luiu_dp.sv -----
`timescale 1ns / 1ps

module luiu_dp
  import luiu_pkg::*;
#(
  parameter int LIST_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_a_i,
  input  logic                 push_b_i,
  input  logic [ElemWidth-1:0] value_i,
  input  logic                 op_i,
  input  ctrl_t                ctrl_i,
  output stat_t                stat_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [ElemWidth-1:0] m_data_o,
  output logic                 m_vres_o,
  output logic                 m_last_o
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [ElemWidth-1:0] mem_a [2**AW];
  logic [ElemWidth-1:0] mem_b [2**AW];

  logic [CW-1:0] cnt_a_q, cnt_b_q, i_q, j_q;
  logic          wsel_q;
  logic          hit_q;
  logic          pend_valid_q;
  logic          out_valid_q;
  logic [ElemWidth-1:0] rd_ai_q, rd_aj_q, rd_bi_q, rd_bj_q;
  logic [ElemWidth-1:0] cand_q, pend_q, out_data_q;
  logic          out_vres_q, out_last_q;

  logic          full_a, full_b;
  logic [CW-1:0] walk_cnt, other_cnt;
  logic [ElemWidth-1:0] walk_rd, other_rd, prefix_rd;
  logic          emit;

  assign full_a = (cnt_a_q == CW'(LIST_DEPTH));
  assign full_b = (cnt_b_q == CW'(LIST_DEPTH));

  // wsel_q set means B is walked and A is searched.
  assign walk_cnt  = wsel_q ? cnt_b_q : cnt_a_q;
  assign other_cnt = wsel_q ? cnt_a_q : cnt_b_q;
  assign walk_rd   = wsel_q ? rd_bi_q : rd_ai_q;
  assign other_rd  = wsel_q ? rd_aj_q : rd_bj_q;
  assign prefix_rd = wsel_q ? rd_bj_q : rd_aj_q;

  assign stat_o.i_end        = (i_q == walk_cnt);
  assign stat_o.j_other_end  = (j_q == other_cnt);
  assign stat_o.j_prefix_end = (j_q == i_q);
  assign stat_o.out_free     = !out_valid_q || m_ready_i;

  assign emit = ctrl_i.emit_all || (ctrl_i.emit_match && (hit_q == op_i));

  // List storage, each with a read port at the walk index and one at the search index.
  always_ff @(posedge clk_i) begin
    if (push_a_i && !full_a) begin
      mem_a[cnt_a_q[AW-1:0]] <= value_i;
    end
    if (push_b_i && !full_b) begin
      mem_b[cnt_b_q[AW-1:0]] <= value_i;
    end
    rd_ai_q <= mem_a[i_q[AW-1:0]];
    rd_aj_q <= mem_a[j_q[AW-1:0]];
    rd_bi_q <= mem_b[i_q[AW-1:0]];
    rd_bj_q <= mem_b[j_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      wsel_q       <= 1'b0;
      hit_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (push_a_i && !full_a) begin
        cnt_a_q <= cnt_a_q + CW'(1);
      end
      if (push_b_i && !full_b) begin
        cnt_b_q <= cnt_b_q + CW'(1);
      end

      case (ctrl_i.wsel)
        WS_A:      wsel_q <= 1'b0;
        WS_B:      wsel_q <= 1'b1;
        WS_LONGER: wsel_q <= !(cnt_a_q > cnt_b_q);
        default:   wsel_q <= wsel_q;
      endcase

      if (ctrl_i.clr_i) begin
        i_q <= '0;
      end else if (ctrl_i.inc_i) begin
        i_q <= i_q + CW'(1);
      end
      if (ctrl_i.clr_j) begin
        j_q <= '0;
      end else if (ctrl_i.inc_j) begin
        j_q <= j_q + CW'(1);
      end

      if (ctrl_i.clr_hit) begin
        hit_q <= 1'b0;
      end else if (ctrl_i.cmp_other && (other_rd == cand_q)) begin
        hit_q <= 1'b1;
      end else if (ctrl_i.cmp_prefix && (prefix_rd == cand_q)) begin
        hit_q <= 1'b1;
      end

      // A found element waits in the pending register until the next one
      // or the end of the compute tells whether it is the last.
      if (ctrl_i.finish) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
        cnt_a_q      <= '0;
        cnt_b_q      <= '0;
      end else if (emit) begin
        pend_valid_q <= 1'b1;
        if (pend_valid_q) begin
          out_valid_q <= 1'b1;
        end else if (m_ready_i) begin
          out_valid_q <= 1'b0;
        end
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cand_q <= walk_rd;
    end
    if (ctrl_i.finish) begin
      out_data_q <= pend_valid_q ? pend_q : '0;
      out_vres_q <= pend_valid_q;
      out_last_q <= 1'b1;
    end else if (emit) begin
      pend_q <= cand_q;
      if (pend_valid_q) begin
        out_data_q <= pend_q;
        out_vres_q <= 1'b1;
        out_last_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_vres_o  = out_vres_q;
  assign m_last_o  = out_last_q;

endmodule

// ----- hdl/list_union_intersection_unit.sv -----
`timescale 1ns / 1ps

// Set union and intersection over two unsorted lists of signed 32-bit values.
// Items with tuser 0 or 1 append tdata to list A or B; a push to a list that
// already holds LIST_DEPTH values is dropped. An item with tuser 2 runs the
// operation held in the configuration register (0 union, 1 intersection),
// streams the result with tlast on its final item, and then empties both
// lists; an empty result is one item with tuser 0 and tdata 0.
// During a compute the input is not ready. A microcoded sequencer walks one
// list and scans the other through registered reads, one compared pair at a
// time: intersection walks the longer list (B on a tie) and scans the other,
// union emits A and then walks B, scanning A and the entries of B before each
// one; the output side can stall the sequencer.
module list_union_intersection_unit
  import luiu_pkg::*;
#(
  parameter int LIST_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[31:0]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // element[31:0]
  output logic        m_axis_tuser,  // valid_res[0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic  op_q;
  logic  busy;
  logic  accept;
  logic  push_a, push_b, start;
  ctrl_t ctrl;
  stat_t stat;

  assign s_axis_tready = !busy;
  assign cfg_ready_o   = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_a        = accept && (s_axis_tuser == MODE_PUSH_A);
  assign push_b        = accept && (s_axis_tuser == MODE_PUSH_B);
  assign start         = accept && (s_axis_tuser == MODE_COMPUTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_UNION;
    end else if (cfg_valid_i && cfg_ready_o) begin
      op_q <= cfg_data_i;
    end
  end

  luiu_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (op_q),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  luiu_dp #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (push_a),
    .push_b_i (push_b),
    .value_i  (s_axis_tdata),
    .op_i     (op_q),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata),
    .m_vres_o (m_axis_tuser),
    .m_last_o (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // A compute item closes the input until its results are produced.
  a_compute_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !s_axis_tready)
    else $error("input still ready after a compute item");

  // The empty-result item is always the final one and carries a zero element.
  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 32'd0)))
    else $error("malformed empty-result item");

  // When a compute ends, its final item is waiting at the output.
  a_end_has_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !$past(busy) == 1'b0 && ctrl.finish) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("compute ended without a final item");
`endif

endmodule

// ----- tb/tb_list_union_intersection_unit.sv -----
`timescale 1ns / 1ps

import luiu_pkg::*;

typedef struct {
  logic [31:0] element;
  logic        valid_res;
  logic        last;
} set_result_t;

// Holds a copy of both lists and the operation, and predicts the result items of each compute.
class set_scoreboard;
  localparam int Depth = 16;

  logic [31:0] list_a[$];
  logic [31:0] list_b[$];
  logic        op_inter;
  set_result_t expected_q[$];
  int          errors;
  int          union_runs;
  int          inter_runs;
  int          empty_runs;
  int          dropped_pushes;
  int          results_seen;

  function new();
    op_inter = OP_UNION;
    errors = 0;
    union_runs = 0;
    inter_runs = 0;
    empty_runs = 0;
    dropped_pushes = 0;
    results_seen = 0;
  endfunction

  function void set_operation(logic op);
    op_inter = op;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function bit held_in(logic [31:0] arr[$], logic [31:0] e);
    foreach (arr[i]) begin
      if (arr[i] == e) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void add_result(logic [31:0] e, logic vr, logic lst);
    set_result_t r;
    r.element = e;
    r.valid_res = vr;
    r.last = lst;
    expected_q = {expected_q, r};
  endfunction

  function void predict_set();
    logic [31:0] emitted[$];
    logic [31:0] walk[$];
    logic [31:0] other[$];
    int first;
    first = expected_q.size();
    if (op_inter == OP_UNION) begin
      union_runs++;
      foreach (list_a[i]) begin
        emitted = {emitted, list_a[i]};
        add_result(list_a[i], 1'b1, 1'b0);
      end
      foreach (list_b[i]) begin
        if (!held_in(emitted, list_b[i])) begin
          emitted = {emitted, list_b[i]};
          add_result(list_b[i], 1'b1, 1'b0);
        end
      end
    end else begin
      inter_runs++;
      // B is walked when both lists have the same length.
      if (list_a.size() > list_b.size()) begin
        walk = list_a;
        other = list_b;
      end else begin
        walk = list_b;
        other = list_a;
      end
      foreach (walk[i]) begin
        if (held_in(other, walk[i])) add_result(walk[i], 1'b1, 1'b0);
      end
    end
    if (expected_q.size() == first) begin
      empty_runs++;
      add_result(32'd0, 1'b0, 1'b1);
    end else begin
      expected_q[expected_q.size() - 1].last = 1'b1;
    end
    list_a.delete();
    list_b.delete();
  endfunction

  function void note_item(mode_e mode, logic [31:0] value);
    case (mode)
      MODE_PUSH_A: begin
        if (list_a.size() < Depth) list_a = {list_a, value};
        else dropped_pushes++;
      end
      MODE_PUSH_B: begin
        if (list_b.size() < Depth) list_b = {list_b, value};
        else dropped_pushes++;
      end
      MODE_COMPUTE: begin
        predict_set();
      end
      default: begin
      end
    endcase
  endfunction

  function void check_result(logic [31:0] e, logic vr, logic lst);
    set_result_t x;
    results_seen++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result item element %h valid_res %b last %b",
               $time, e, vr, lst);
      errors++;
      return;
    end
    x = expected_q.pop_front();
    if (e !== x.element) begin
      $display("%0t: element expected %h got %h", $time, x.element, e);
      errors++;
    end
    if (vr !== x.valid_res) begin
      $display("%0t: valid_res expected %b got %b", $time, x.valid_res, vr);
      errors++;
    end
    if (lst !== x.last) begin
      $display("%0t: last expected %b got %b", $time, x.last, lst);
      errors++;
    end
  endfunction
endclass

module tb_list_union_intersection_unit;

  localparam int StallMax = 13;
  localparam int SettleCycles = 24;
  localparam int WatchdogLimit = 8000;
  localparam int TargetItems = 160;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  set_scoreboard board;
  bit            tx_burst;
  bit            rx_burst;
  int            item_count;
  int            idle_cycles;
  logic [31:0]   value_pool[$];

  list_union_intersection_unit #(
    .LIST_DEPTH(16)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Nothing accepted on any channel for too long means the block hung.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d results still expected", $time, board.pending());
      $display("tb_list_union_intersection_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: random stalls per item, none while rx_burst is set.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, StallMax);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_item(input mode_e mode, input logic [31:0] value, input bit counted);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, StallMax);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(mode, value);
    if (counted) item_count++;
  endtask

  // Stops sending and waits until every expected item is back and the sequencer is done.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_operation(input logic op);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= op;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_operation(op);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    if (value_pool.size() == 0 || $urandom_range(0, 3) == 0) return $urandom();
    return value_pool[$urandom_range(0, value_pool.size() - 1)];
  endfunction

  function automatic int pick_length();
    if ($urandom_range(0, 5) == 0) return $urandom_range(14, 19);
    return $urandom_range(0, 8);
  endfunction

  task automatic random_phase();
    int na;
    int nb;
    logic [31:0] v;
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) begin
      drain();
      write_operation(1'($urandom_range(0, 1)));
    end
    value_pool.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 5))
        0: v = 32'h7fff_ffff;
        1: v = 32'h8000_0000;
        2: v = 32'hffff_ffff;
        default: v = $urandom();
      endcase
      value_pool = {value_pool, v};
    end
    na = pick_length();
    nb = pick_length();
    while (na > 0 || nb > 0) begin
      if ($urandom_range(0, 11) == 0) send_item(MODE_UNUSED, $urandom(), 1'b0);
      if (nb == 0 || (na > 0 && $urandom_range(0, 1) == 0)) begin
        send_item(MODE_PUSH_A, pick_value(), 1'b1);
        na--;
      end else begin
        send_item(MODE_PUSH_B, pick_value(), 1'b1);
        nb--;
      end
    end
    send_item(MODE_COMPUTE, $urandom(), 1'b1);
  endtask

  initial begin
    board = new();
    item_count = 0;
    idle_cycles = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_PUSH_A;
    cfg_valid_i = 1'b0;
    cfg_data_i = OP_UNION;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty union, extreme values, duplicates, an unused mode, and
    // intersections with A longer, equal lengths and both lists empty.
    write_operation(OP_UNION);
    send_item(MODE_COMPUTE, 32'd0, 1'b1);
    send_item(MODE_PUSH_A, 32'h7fff_ffff, 1'b1);
    send_item(MODE_PUSH_A, 32'h8000_0000, 1'b1);
    send_item(MODE_PUSH_A, 32'h0000_0000, 1'b1);
    send_item(MODE_PUSH_A, 32'hffff_ffff, 1'b1);
    send_item(MODE_PUSH_B, 32'hffff_ffff, 1'b1);
    send_item(MODE_PUSH_B, 32'h8000_0000, 1'b1);
    send_item(MODE_PUSH_B, 32'd7, 1'b1);
    send_item(MODE_UNUSED, 32'h5a5a_a5a5, 1'b0);
    send_item(MODE_COMPUTE, 32'hffff_ffff, 1'b1);
    drain();
    write_operation(OP_INTER);
    send_item(MODE_PUSH_A, 32'd2, 1'b1);
    send_item(MODE_PUSH_A, 32'd2, 1'b1);
    send_item(MODE_PUSH_A, 32'd3, 1'b1);
    send_item(MODE_PUSH_A, 32'hffff_fffb, 1'b1);
    send_item(MODE_PUSH_B, 32'd2, 1'b1);
    send_item(MODE_PUSH_B, 32'hffff_fffb, 1'b1);
    send_item(MODE_COMPUTE, 32'd0, 1'b1);
    send_item(MODE_PUSH_A, 32'd4, 1'b1);
    send_item(MODE_PUSH_A, 32'd9, 1'b1);
    send_item(MODE_PUSH_B, 32'd9, 1'b1);
    send_item(MODE_PUSH_B, 32'd4, 1'b1);
    send_item(MODE_COMPUTE, 32'd0, 1'b1);
    send_item(MODE_COMPUTE, 32'd0, 1'b1);

    while (item_count < TargetItems) random_phase();
    drain();

    $display("Sent %0d counted items: %0d unions, %0d intersections, %0d empty results.",
             item_count, board.union_runs, board.inter_runs, board.empty_runs);
    $display("Checked %0d result items; %0d pushes to a full list were dropped.",
             board.results_seen, board.dropped_pushes);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_list_union_intersection_unit OK");
    end else begin
      $display("tb_list_union_intersection_unit NOT OK");
    end
    $finish;
  end

endmodule
